FILE: rtl/rptme_pkg.sv
// ----------------------------------------------------------------------------
// RE pattern table mask engine package
// Shared types and constants for the pattern table and its command path.
// ----------------------------------------------------------------------------
package rptme_pkg;

    localparam int MAX_PATTERNS_DEF = 4;
    localparam int NUM_RB_DEF = 275;
    localparam int SC_PER_RB = 12;
    localparam int SYMBOLS_PER_SLOT_DEF = 14;

    typedef enum logic [1:0] {
        CMD_MERGE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_COVERED   = 3'd1,
        ST_SC_MERGED = 3'd2,
        ST_SYM_MERGE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOD,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  rb_first;
        logic [8:0]  rb_stop;
        logic [8:0]  rb_step;
        logic [11:0] sc_mask;
        logic [13:0] symbol_mask;
        logic [8:0]  rb_index;
        logic [3:0]  symbol;
        logic [3:0]  symbol_count;
        logic [11:0] mask_in;
        logic        last_rb;
    } t_item;

    typedef struct packed {
        logic [8:0]  rb_first;
        logic [8:0]  rb_stop;
        logic [8:0]  rb_step;
        logic [11:0] sc_mask;
        logic [13:0] symbol_mask;
    } t_pattern;

    function automatic logic [3:0] popcount12(input logic [11:0] v);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < SC_PER_RB; k++) begin
            c = c + {3'd0, v[k]};
        end
        return c;
    endfunction

endpackage

FILE: rtl/rptme_front.sv
// ----------------------------------------------------------------------------
// RE pattern table front end
// Accepts command transactions, drops unknown commands into the queue as
// they are, and buffers them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rptme_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rptme_pkg::t_item i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output rptme_pkg::t_item o_item
);
    rptme_pkg::t_item r_q [2];
    logic             r_rd;
    logic             r_wr;
    logic [1:0]       r_cnt;
    logic             n_push;
    logic             n_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign n_push  = i_valid && o_ready;
    assign n_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, n_push} - {1'b0, n_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wr] <= i_item;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cnt == 2'd2 && n_push)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cnt == 2'd0 && n_pop)) else $error("pop from empty queue");
endmodule

FILE: rtl/rptme_back.sv
// ----------------------------------------------------------------------------
// RE pattern table back end
// Walks the pattern table entry by entry for merge, query and count, using
// a restoring bit-serial remainder unit for the stride test.
// ----------------------------------------------------------------------------
module rptme_back #(
    parameter int MAX_PATTERNS     = rptme_pkg::MAX_PATTERNS_DEF,
    parameter int NUM_RB           = rptme_pkg::NUM_RB_DEF,
    parameter int SYMBOLS_PER_SLOT = rptme_pkg::SYMBOLS_PER_SLOT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rptme_pkg::t_item i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [11:0]      o_include_mask,
    output logic [11:0]      o_exclude_mask,
    output logic [15:0]      o_re_count,
    output logic             o_count_done
);
    localparam int IW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int UW = $clog2(MAX_PATTERNS + 1);

    rptme_pkg::t_state   r_state, n_state;
    rptme_pkg::t_item    r_it;
    rptme_pkg::t_pattern r_tab [MAX_PATTERNS];
    logic [UW-1:0]       r_used;
    logic [UW-1:0]       r_idx;
    logic [15:0]         r_acc;
    logic [11:0]         r_inc;
    logic [11:0]         r_exc;
    logic [3:0]          r_sym;
    logic [16:0]         r_add;
    logic [8:0]          r_rem;
    logic [8:0]          r_num;
    logic [3:0]          r_bit;
    logic                r_merged;
    logic [2:0]          r_status;
    logic                r_ovalid;
    logic [2:0]          r_ostat;
    logic [11:0]         r_oinc;
    logic [11:0]         r_oexc;
    logic [15:0]         r_ocnt;
    logic                r_odone;

    rptme_pkg::t_pattern w_p;
    rptme_pkg::t_item    w_it;
    logic [IW-1:0]       w_i;
    logic                w_last;
    logic                w_uses;
    logic                w_range;
    logic [3:0]          w_send;
    logic [8:0]          w_diff;
    logic [9:0]          w_trial;
    logic                w_out_free;
    logic [16:0]         w_sum;

    assign w_i     = r_idx[IW-1:0];
    assign w_p     = r_tab[w_i];
    assign w_last  = (r_idx >= r_used) || (r_idx >= UW'(MAX_PATTERNS));
    assign w_uses  = (r_sym < 4'(SYMBOLS_PER_SLOT)) && w_p.symbol_mask[r_sym];
    assign w_range = (r_it.rb_index < 9'(NUM_RB)) && (r_it.rb_index >= w_p.rb_first)
                     && (r_it.rb_index < w_p.rb_stop);
    assign w_diff  = r_it.rb_index - w_p.rb_first;
    assign w_trial = {r_rem, r_num[8]} - {1'b0, w_p.rb_step};
    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == rptme_pkg::S_IDLE);
    assign w_sum   = {1'b0, r_acc} + r_add;

    always_comb begin
        logic [4:0] e;
        e = {1'b0, i_item.symbol} + {1'b0, i_item.symbol_count};
        if (e > 5'(SYMBOLS_PER_SLOT)) begin
            e = 5'(SYMBOLS_PER_SLOT);
        end
        w_send = e[3:0];
        w_it = i_item;
        w_it.symbol_count = (w_send > i_item.symbol) ? w_send : i_item.symbol;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rptme_pkg::S_IDLE: if (i_valid) n_state = rptme_pkg::S_SCAN;
            rptme_pkg::S_SCAN: begin
                if (w_last) begin
                    n_state = rptme_pkg::S_NEXT;
                end else if (r_it.cmd == rptme_pkg::CMD_MERGE) begin
                    n_state = rptme_pkg::S_SCAN;
                end else if (w_uses && w_range && w_p.rb_step != 9'd0) begin
                    n_state = rptme_pkg::S_MOD;
                end
            end
            rptme_pkg::S_MOD: if (r_bit == 4'd8) n_state = rptme_pkg::S_SCAN;
            rptme_pkg::S_NEXT: n_state = rptme_pkg::S_DONE;
            rptme_pkg::S_DONE: if (w_out_free) n_state = rptme_pkg::S_IDLE;
            default: n_state = rptme_pkg::S_IDLE;
        endcase
        if (r_state == rptme_pkg::S_SCAN && !w_last && r_it.cmd == rptme_pkg::CMD_MERGE
            && r_merged) begin
            n_state = rptme_pkg::S_NEXT;
        end
        if (r_state == rptme_pkg::S_NEXT && r_it.cmd == rptme_pkg::CMD_COUNT
            && ({1'b0, r_sym} + 5'd1) < {1'b0, r_it.symbol_count}) begin
            n_state = rptme_pkg::S_SCAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rptme_pkg::S_IDLE;
            r_used   <= '0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rptme_pkg::S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                rptme_pkg::S_NEXT: begin
                    if (r_it.cmd == rptme_pkg::CMD_MERGE && r_status == rptme_pkg::ST_APPENDED) begin
                        r_used <= r_used + UW'(1);
                    end
                end
                rptme_pkg::S_DONE: begin
                    if (w_out_free && r_it.cmd == rptme_pkg::CMD_COUNT) begin
                        r_acc <= r_it.last_rb ? 16'd0
                               : (w_sum[16] ? 16'hFFFF : w_sum[15:0]);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rptme_pkg::S_IDLE: begin
                r_it         <= w_it;
                r_idx        <= '0;
                r_inc        <= '0;
                r_exc        <= '0;
                r_sym        <= i_item.symbol;
                r_add        <= '0;
                r_merged     <= 1'b0;
                r_status     <= rptme_pkg::ST_APPENDED;
            end
            rptme_pkg::S_SCAN: begin
                if (!w_last) begin
                    if (r_it.cmd == rptme_pkg::CMD_MERGE) begin
                        if (!r_merged) begin
                            r_idx <= r_idx + UW'(1);
                            if (w_p.rb_first == r_it.rb_first && w_p.rb_stop == r_it.rb_stop
                                && w_p.rb_step == r_it.rb_step) begin
                                if (w_p.symbol_mask == r_it.symbol_mask
                                    && w_p.sc_mask == r_it.sc_mask) begin
                                    r_merged <= 1'b1;
                                    r_status <= rptme_pkg::ST_COVERED;
                                end else if (w_p.symbol_mask == r_it.symbol_mask) begin
                                    r_merged <= 1'b1;
                                    r_status <= rptme_pkg::ST_SC_MERGED;
                                    r_tab[w_i].sc_mask <= w_p.sc_mask | r_it.sc_mask;
                                end else if (w_p.sc_mask == r_it.sc_mask) begin
                                    r_merged <= 1'b1;
                                    r_status <= rptme_pkg::ST_SYM_MERGE;
                                    r_tab[w_i].symbol_mask <= w_p.symbol_mask
                                                              | r_it.symbol_mask;
                                end
                            end
                        end
                    end else if (w_uses && w_range) begin
                        r_exc <= r_exc | w_p.sc_mask;
                        if (w_p.rb_step == 9'd0) begin
                            if (w_diff == 9'd0) r_inc <= r_inc | w_p.sc_mask;
                            r_idx <= r_idx + UW'(1);
                        end else begin
                            r_rem <= '0;
                            r_num <= w_diff;
                            r_bit <= '0;
                        end
                    end else begin
                        r_idx <= r_idx + UW'(1);
                    end
                end else if (r_it.cmd == rptme_pkg::CMD_MERGE && !r_merged) begin
                    if (r_used >= UW'(MAX_PATTERNS)) begin
                        r_status <= rptme_pkg::ST_FULL;
                    end else begin
                        r_tab[r_used[IW-1:0]] <= '{r_it.rb_first, r_it.rb_stop, r_it.rb_step,
                                                   r_it.sc_mask, r_it.symbol_mask};
                    end
                end
            end
            rptme_pkg::S_MOD: begin
                r_num <= {r_num[7:0], 1'b0};
                r_bit <= r_bit + 4'd1;
                if (!w_trial[9]) r_rem <= w_trial[8:0];
                else r_rem <= {r_rem[7:0], r_num[8]};
                if (r_bit == 4'd8) begin
                    r_idx <= r_idx + UW'(1);
                    if ((w_trial[9] ? {r_rem[7:0], r_num[8]} : w_trial[8:0]) == 9'd0) begin
                        r_inc <= r_inc | w_p.sc_mask;
                    end
                end
            end
            rptme_pkg::S_NEXT: begin
                if (r_it.cmd == rptme_pkg::CMD_COUNT) begin
                    if (r_sym < r_it.symbol_count) begin
                        r_add <= r_add + {13'd0, rptme_pkg::popcount12(r_inc)};
                    end
                    r_sym <= r_sym + 4'd1;
                    r_idx <= '0;
                    r_inc <= '0;
                end
            end
            rptme_pkg::S_DONE: begin
                if (w_out_free) begin
                    case (r_it.cmd)
                        rptme_pkg::CMD_MERGE: begin
                            r_ostat <= r_status;
                            r_oinc  <= '0;
                            r_oexc  <= '0;
                            r_ocnt  <= '0;
                            r_odone <= 1'b0;
                        end
                        rptme_pkg::CMD_QUERY: begin
                            r_ostat <= '0;
                            r_oinc  <= r_it.mask_in | r_inc;
                            r_oexc  <= r_it.mask_in & ~r_exc;
                            r_ocnt  <= '0;
                            r_odone <= 1'b0;
                        end
                        rptme_pkg::CMD_COUNT: begin
                            r_ostat <= '0;
                            r_oinc  <= '0;
                            r_oexc  <= '0;
                            r_ocnt  <= w_sum[16] ? 16'hFFFF : w_sum[15:0];
                            r_odone <= r_it.last_rb;
                        end
                        default: begin
                            r_ostat <= '0;
                            r_oinc  <= '0;
                            r_oexc  <= '0;
                            r_ocnt  <= '0;
                            r_odone <= 1'b0;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostat;
    assign o_include_mask = r_oinc;
    assign o_exclude_mask = r_oexc;
    assign o_re_count     = r_ocnt;
    assign o_count_done   = r_odone;

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_PATTERNS)) else $error("table overfilled");
    a_bit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != rptme_pkg::S_MOD || r_bit <= 4'd8) else $error("remainder step overrun");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (r_state == rptme_pkg::S_IDLE)) else $error("ready outside idle");
endmodule

FILE: rtl/re_pattern_table_mask_engine_top.sv
// ----------------------------------------------------------------------------
// RE pattern table mask engine, top level
// A front queue decouples command intake from the table-walking back end.
//
// Channel | Direction | Handshake
// in      | input     | i_valid / o_ready, command fields
// out     | output    | o_valid / i_ready, result fields
//
// A merge walks the table entry by entry until it merges with one. A query
// walks every entry and runs the bit-serial stride remainder for each
// covering strided entry. A count repeats the query walk once per symbol.
// Reset is synchronous and clears the entry count and the accumulator.
// Stalls at the output hold the back end; the queue keeps taking two items.
// ----------------------------------------------------------------------------
module re_pattern_table_mask_engine_top #(
    parameter int MAX_PATTERNS     = rptme_pkg::MAX_PATTERNS_DEF,
    parameter int NUM_RB           = rptme_pkg::NUM_RB_DEF,
    parameter int SYMBOLS_PER_SLOT = rptme_pkg::SYMBOLS_PER_SLOT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [8:0]  i_rb_first,
    input  logic [8:0]  i_rb_stop,
    input  logic [8:0]  i_rb_step,
    input  logic [11:0] i_sc_mask,
    input  logic [13:0] i_symbol_mask,
    input  logic [8:0]  i_rb_index,
    input  logic [3:0]  i_symbol,
    input  logic [3:0]  i_symbol_count,
    input  logic [11:0] i_mask_in,
    input  logic        i_last_rb,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [11:0] o_include_mask,
    output logic [11:0] o_exclude_mask,
    output logic [15:0] o_re_count,
    output logic        o_count_done
);
    rptme_pkg::t_item w_in;
    rptme_pkg::t_item w_q;
    logic             w_qv;
    logic             w_qr;

    assign w_in = '{i_cmd, i_rb_first, i_rb_stop, i_rb_step, i_sc_mask, i_symbol_mask,
                    i_rb_index, i_symbol, i_symbol_count, i_mask_in, i_last_rb};

    rptme_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    rptme_back #(
        .MAX_PATTERNS(MAX_PATTERNS), .NUM_RB(NUM_RB), .SYMBOLS_PER_SLOT(SYMBOLS_PER_SLOT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_include_mask(o_include_mask),
        .o_exclude_mask(o_exclude_mask), .o_re_count(o_re_count),
        .o_count_done(o_count_done)
    );
endmodule

FILE: tb/tb_re_pattern_table_mask_engine_top.sv
// ----------------------------------------------------------------------------
// Testbench for the RE pattern table mask engine
// Drives merge, query and count transactions, predicts each result from a
// local model of the pattern table and accumulator, and compares every field.
// ----------------------------------------------------------------------------
module tb_re_pattern_table_mask_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PAT = 4;
    localparam int N_RB = 275;
    localparam int N_SYM = 14;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] incl;
        logic [11:0] excl;
        logic [15:0] count;
        logic        done;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic [8:0]  i_rb_first = '0;
    logic [8:0]  i_rb_stop = '0;
    logic [8:0]  i_rb_step = '0;
    logic [11:0] i_sc_mask = '0;
    logic [13:0] i_symbol_mask = '0;
    logic [8:0]  i_rb_index = '0;
    logic [3:0]  i_symbol = '0;
    logic [3:0]  i_symbol_count = '0;
    logic [11:0] i_mask_in = '0;
    logic        i_last_rb = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [11:0] o_include_mask;
    logic [11:0] o_exclude_mask;
    logic [15:0] o_re_count;
    logic        o_count_done;

    rptme_pkg::t_pattern tbl[N_PAT];
    int         used;
    int         accum;
    t_result    expected_q[$];
    int         mismatches;
    int         idle_cycles;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         n_merge, n_query, n_count;
    bit         timed_out;

    re_pattern_table_mask_engine_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic bit covers(rptme_pkg::t_pattern p, int rb, bit strided);
        if (rb >= N_RB || rb < p.rb_first || rb >= p.rb_stop) return 0;
        if (!strided) return 1;
        if (p.rb_step == 0) return rb == p.rb_first;
        return ((rb - p.rb_first) % p.rb_step) == 0;
    endfunction

    function automatic logic [11:0] pattern_bits(int rb, int sym, bit strided);
        logic [11:0] m;
        m = '0;
        for (int i = 0; i < used; i++)
            if (sym < N_SYM && tbl[i].symbol_mask[sym] && covers(tbl[i], rb, strided))
                m |= tbl[i].sc_mask;
        return m;
    endfunction

    function automatic rptme_pkg::t_status merge_pattern(rptme_pkg::t_pattern n);
        for (int i = 0; i < used; i++) begin
            if (tbl[i].rb_first != n.rb_first || tbl[i].rb_stop != n.rb_stop ||
                tbl[i].rb_step != n.rb_step) continue;
            if (tbl[i].symbol_mask == n.symbol_mask && tbl[i].sc_mask == n.sc_mask)
                return rptme_pkg::ST_COVERED;
            if (tbl[i].symbol_mask == n.symbol_mask) begin
                tbl[i].sc_mask |= n.sc_mask;
                return rptme_pkg::ST_SC_MERGED;
            end
            if (tbl[i].sc_mask == n.sc_mask) begin
                tbl[i].symbol_mask |= n.symbol_mask;
                return rptme_pkg::ST_SYM_MERGE;
            end
        end
        if (used >= N_PAT) return rptme_pkg::ST_FULL;
        tbl[used] = n;
        used++;
        return rptme_pkg::ST_APPENDED;
    endfunction

    function automatic t_result predict_result(rptme_pkg::t_item it);
        t_result r;
        rptme_pkg::t_pattern n;
        int last_sym;
        r = '0;
        case (rptme_pkg::t_cmd'(it.cmd))
            rptme_pkg::CMD_MERGE: begin
                n = {it.rb_first, it.rb_stop, it.rb_step, it.sc_mask, it.symbol_mask};
                r.status = merge_pattern(n);
            end
            rptme_pkg::CMD_QUERY: begin
                r.incl = it.mask_in | pattern_bits(it.rb_index, it.symbol, 1);
                r.excl = it.mask_in & ~pattern_bits(it.rb_index, it.symbol, 0);
            end
            rptme_pkg::CMD_COUNT: begin
                last_sym = it.symbol + it.symbol_count;
                if (last_sym > N_SYM) last_sym = N_SYM;
                for (int s = it.symbol; s < last_sym; s++)
                    accum += $countones(pattern_bits(it.rb_index, s, 1));
                if (accum > 65535) accum = 65535;
                r.count = 16'(accum);
                r.done = it.last_rb;
                if (it.last_rb) accum = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(rptme_pkg::t_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        expected_q.push_back(predict_result(it));
        case (rptme_pkg::t_cmd'(it.cmd))
            rptme_pkg::CMD_MERGE: n_merge++;
            rptme_pkg::CMD_QUERY: n_query++;
            rptme_pkg::CMD_COUNT: n_count++;
            default: ;
        endcase
        i_valid <= 1'b1;
        {i_cmd, i_rb_first, i_rb_stop, i_rb_step, i_sc_mask, i_symbol_mask,
         i_rb_index, i_symbol, i_symbol_count, i_mask_in, i_last_rb} <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic rptme_pkg::t_item rand_item();
        rptme_pkg::t_item it;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        it = bits[$bits(rptme_pkg::t_item)-1:0];
        it.symbol = 4'($urandom_range(15));
        it.symbol_count = 4'($urandom_range(15));
        return it;
    endfunction

    function automatic rptme_pkg::t_item merge_item(int first, int stop, int step,
                                                    logic [11:0] sc, logic [13:0] sym);
        rptme_pkg::t_item it;
        it = rand_item();
        it.cmd = rptme_pkg::CMD_MERGE;
        it.rb_first = 9'(first);
        it.rb_stop = 9'(stop);
        it.rb_step = 9'(step);
        it.sc_mask = sc;
        it.symbol_mask = sym;
        return it;
    endfunction

    function automatic rptme_pkg::t_item query_item(int rb, int sym, logic [11:0] m);
        rptme_pkg::t_item it;
        it = rand_item();
        it.cmd = rptme_pkg::CMD_QUERY;
        it.rb_index = 9'(rb);
        it.symbol = 4'(sym);
        it.mask_in = m;
        return it;
    endfunction

    function automatic rptme_pkg::t_item count_item(int rb, int sym, int cnt, bit last);
        rptme_pkg::t_item it;
        it = rand_item();
        it.cmd = rptme_pkg::CMD_COUNT;
        it.rb_index = 9'(rb);
        it.symbol = 4'(sym);
        it.symbol_count = 4'(cnt);
        it.last_rb = last;
        return it;
    endfunction

    // Results are checked on the rising edge; the ready level is changed
    // at the falling edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_include_mask, o_exclude_mask, o_re_count, o_count_done};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected transaction %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: status %0d/%0d incl %h/%h excl %h/%h count %0d/%0d done %0d/%0d (exp/act)",
                                 want.status, got.status, want.incl, got.incl, want.excl,
                                 got.excl, want.count, got.count, want.done, got.done);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_merge_directed();
        send_item(query_item(0, 0, 12'hABC));
        send_item(count_item(0, 0, 14, 1));
        send_item(merge_item(0, 275, 1, 12'hFFF, 14'h3FFF));
        send_item(merge_item(0, 275, 1, 12'hFFF, 14'h3FFF));
        send_item(merge_item(10, 20, 3, 12'h00F, 14'h0001));
        send_item(merge_item(10, 20, 3, 12'h0F0, 14'h0001));
        send_item(merge_item(10, 20, 3, 12'h0FF, 14'h2000));
        send_item(merge_item(274, 275, 0, 12'h800, 14'h2000));
        send_item(merge_item(5, 9, 275, 12'h001, 14'h0002));
        send_item(merge_item(400, 511, 511, 12'h000, 14'h0000));
    endtask

    task automatic test_query_count_directed();
        rptme_pkg::t_item it;
        send_item(query_item(0, 0, 12'h000));
        send_item(query_item(13, 13, 12'hFFF));
        send_item(query_item(274, 13, 12'h555));
        send_item(query_item(275, 0, 12'hAAA));
        send_item(query_item(511, 15, 12'h0F0));
        send_item(query_item(12, 14, 12'hFFF));
        send_item(count_item(10, 0, 14, 0));
        send_item(count_item(13, 10, 15, 0));
        send_item(count_item(300, 0, 14, 0));
        send_item(count_item(274, 15, 15, 1));
        send_item(count_item(16, 0, 0, 1));
        it = rand_item();
        it.cmd = rptme_pkg::CMD_NONE;
        send_item(it);
    endtask

    task automatic test_random(int n);
        rptme_pkg::t_item it;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // Small pool of ranges so that merges often hit an existing entry.
                it = merge_item($urandom_range(3) * 40, 60 + $urandom_range(3) * 70,
                                $urandom_range(3), 12'h1 << $urandom_range(11),
                                14'h1 << $urandom_range(13));
                if ($urandom_range(3) == 0) it = rand_item();
                it.cmd = rptme_pkg::CMD_MERGE;
            end else if (pick < 50) begin
                it = query_item($urandom_range(280), $urandom_range(14), 12'($urandom));
                if ($urandom_range(9) == 0) it.rb_index = 9'($urandom);
            end else if (pick < 97) begin
                it = count_item($urandom_range(280), $urandom_range(14),
                                $urandom_range(15), $urandom_range(7) == 0);
            end else begin
                it = rand_item();
            end
            send_item(it);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        used = 0;
        accum = 0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 0;
        send_idle_pct = 9;
        recv_idle_pct = 46;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_merge_directed();
        test_query_count_directed();
        test_random(380);
        send_idle_pct = 46;
        recv_idle_pct = 9;
        test_random(380);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(370);
        drain();
        $display("Covered %0d merge, %0d query and %0d count transactions", n_merge, n_query,
                 n_count);
        $display("with sender and receiver idling swapped and finally no idling.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/rptme_pkg.sv
rtl/rptme_front.sv
rtl/rptme_back.sv
rtl/re_pattern_table_mask_engine_top.sv
tb/tb_re_pattern_table_mask_engine_top.sv
